// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising edge outside reset
`define LSWS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same-cycle implication
`define LSWS_IMPLY(label, ante, cons, msg) \
  `LSWS_ASSERT(label, (ante) |-> (cons), msg)

// next-cycle implication
`define LSWS_IMPLY_NEXT(label, ante, cons, msg) \
  `LSWS_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== rtl/lsws_pkg.sv =====
package lsws_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned DepthW = 7;
  localparam int unsigned PosW   = 6;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_NOP    = 2'd3
  } lsws_cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } lsws_status_e;

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } lsws_state_e;

  typedef struct packed {
    lsws_cmd_e               command;
    logic signed [DataW-1:0] value;
  } lsws_req_t;

  typedef struct packed {
    logic signed [DataW-1:0] top_value;
    logic [DepthW-1:0]       depth;
    logic                    found;
    logic [PosW-1:0]         found_position;
    lsws_status_e            status;
  } lsws_rsp_t;

  typedef struct packed {
    logic push;
    logic pop;
  } lsws_shift_t;

endpackage

// ===== rtl/lsws_cell.sv =====
module lsws_cell import lsws_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lsws_shift_t             shift_i,
  input  logic signed [DataW-1:0] above_i,
  input  logic signed [DataW-1:0] below_i,
  input  logic signed [DataW-1:0] key_i,
  input  logic                    live_i,
  output logic signed [DataW-1:0] data_o,
  output logic                    match_o
);

  logic signed [DataW-1:0] data_q, data_d;
  logic                    match_q, match_d;

  always_comb begin
    data_d = data_q;
    if (shift_i.push) begin
      data_d = above_i;
    end else if (shift_i.pop) begin
      data_d = below_i;
    end
  end

  assign match_d = live_i && (data_q == key_i);

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

// ===== rtl/lsws_node.sv =====
module lsws_node #(
  parameter int unsigned IdxW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            lo_hit_i,
  input  logic [IdxW-1:0] lo_idx_i,
  input  logic            hi_hit_i,
  input  logic [IdxW-1:0] hi_idx_i,
  output logic            hit_o,
  output logic [IdxW-1:0] idx_o
);

  logic            hit_q, hit_d;
  logic [IdxW-1:0] idx_q, idx_d;

  // prefer the deeper cell: it holds the lower stack position
  assign hit_d = lo_hit_i | hi_hit_i;
  assign idx_d = hi_hit_i ? hi_idx_i : lo_idx_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
  end

  assign hit_o = hit_q;
  assign idx_o = idx_q;

endmodule

// ===== rtl/lifo_stack_with_search_unit.sv =====
// Channel   Dir  Handshake                 Payload
// request   in   req_valid_i / req_stall_o  req_i (lsws_req_t)
// response  out  rsp_valid_o / rsp_stall_i  rsp_o (lsws_rsp_t)
//
// Push, pop and no-op run at one request a cycle unless the request port stalls.
// Search on a non-empty stack runs the per-cell compare then a registered
// priority tree of ceil(log2(STACK_DEPTH)) levels; the request port stalls
// until the search response is registered into the response stage.
// Reset clears the fill count, sequencer and response stage; stored words stay
// undefined until pushed, no clearing pass.
// A stalled response holds while one more parks in a spare register.
module lifo_stack_with_search_unit import lsws_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_stall_o,
  input  lsws_req_t req_i,
  output logic      rsp_valid_o,
  input  logic      rsp_stall_i,
  output lsws_rsp_t rsp_o
);

  localparam int unsigned CntW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IdxW   = $clog2(STACK_DEPTH);
  localparam int unsigned Leaves = 1 << IdxW;
  localparam int unsigned WaitW  = $clog2(IdxW + 2);

  lsws_state_e             state_q, state_d;
  logic [CntW-1:0]         count_q, count_d;
  logic [WaitW-1:0]        wait_q, wait_d;
  logic signed [DataW-1:0] key_q;

  logic        accept;
  logic        is_full, is_empty;
  lsws_shift_t shift;

  logic signed [DataW-1:0] cell_data  [STACK_DEPTH];
  logic                    cell_match [STACK_DEPTH];
  logic                    hit_w      [1:2*Leaves-1];
  logic [IdxW-1:0]         idx_w      [1:2*Leaves-1];

  logic      res_we;
  lsws_rsp_t res;

  lsws_rsp_t head_q, head_d, spare_q, spare_d;
  logic      head_v_q, head_v_d, spare_v_q, spare_v_d;
  logic      rd;

  assign is_full  = (count_q == CntW'(STACK_DEPTH));
  assign is_empty = (count_q == '0);
  assign accept   = req_valid_i && !req_stall_o;

  assign shift.push = accept && (req_i.command == CMD_PUSH) && !is_full;
  assign shift.pop  = accept && (req_i.command == CMD_POP) && !is_empty;

  always_comb begin
    count_d = count_q;
    if (shift.push) begin
      count_d = count_q + CntW'(1);
    end else if (shift.pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
    logic signed [DataW-1:0] above, below;
    if (k == 0) begin : g_first
      assign above = req_i.value;
    end else begin : g_mid
      assign above = cell_data[k-1];
    end
    if (k == STACK_DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_inner
      assign below = cell_data[k+1];
    end
    lsws_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .above_i (above),
      .below_i (below),
      .key_i   (key_q),
      .live_i  (CntW'(k) < count_q),
      .data_o  (cell_data[k]),
      .match_o (cell_match[k])
    );
  end

  for (genvar k = 0; k < Leaves; k++) begin : g_leaf
    if (k < STACK_DEPTH) begin : g_used
      assign hit_w[Leaves+k] = cell_match[k];
    end else begin : g_pad
      assign hit_w[Leaves+k] = 1'b0;
    end
    assign idx_w[Leaves+k] = IdxW'(k);
  end

  for (genvar i = 1; i < Leaves; i++) begin : g_node
    lsws_node #(.IdxW(IdxW)) u_node (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .lo_hit_i (hit_w[2*i]),
      .lo_idx_i (idx_w[2*i]),
      .hi_hit_i (hit_w[2*i+1]),
      .hi_idx_i (idx_w[2*i+1]),
      .hit_o    (hit_w[i]),
      .idx_o    (idx_w[i])
    );
  end

  always_comb begin
    state_d = state_q;
    wait_d  = wait_q;
    case (state_q)
      S_IDLE: begin
        wait_d = WaitW'(IdxW + 1);
        if (accept && (req_i.command == CMD_SEARCH) && !is_empty) begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (wait_q == '0) begin
          state_d = S_IDLE;
        end else begin
          wait_d = wait_q - WaitW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    req_stall_o        = (state_q == S_SEARCH) || spare_v_q;
    res_we             = 1'b0;
    res.top_value      = is_empty ? '0 : cell_data[0];
    res.depth          = DepthW'(count_d);
    res.found          = 1'b0;
    res.found_position = '0;
    res.status         = STAT_OK;
    case (state_q)
      S_IDLE: begin
        res_we = accept && !((req_i.command == CMD_SEARCH) && !is_empty);
        case (req_i.command)
          CMD_PUSH: begin
            if (is_full) begin
              res.status = STAT_FULL;
            end else begin
              res.top_value = req_i.value;
            end
          end
          CMD_POP: begin
            if (is_empty) begin
              res.status = STAT_EMPTY;
            end else if (count_q == CntW'(1)) begin
              res.top_value = '0;
            end else begin
              res.top_value = cell_data[1];
            end
          end
          CMD_SEARCH: begin
            if (is_empty) begin
              res.status = STAT_EMPTY;
            end
          end
          default: begin
            res.status = STAT_OK;
          end
        endcase
      end
      S_SEARCH: begin
        res_we    = (wait_q == '0);
        res.found = hit_w[1];
        if (hit_w[1]) begin
          res.found_position =
            PosW'(CntW'(count_q - CntW'(1) - CntW'(idx_w[1])));
        end
      end
      default: begin
        res_we = 1'b0;
      end
    endcase
  end

  assign rd = head_v_q && !rsp_stall_i;

  always_comb begin
    head_d    = head_q;
    spare_d   = spare_q;
    head_v_d  = head_v_q;
    spare_v_d = spare_v_q;
    if (rd) begin
      if (spare_v_q) begin
        head_d    = spare_q;
        spare_v_d = res_we;
        spare_d   = res;
      end else begin
        head_v_d = res_we;
        head_d   = res;
      end
    end else if (res_we) begin
      if (!head_v_q) begin
        head_v_d = 1'b1;
        head_d   = res;
      end else begin
        spare_v_d = 1'b1;
        spare_d   = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      wait_q    <= '0;
      head_v_q  <= 1'b0;
      spare_v_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      wait_q    <= wait_d;
      head_v_q  <= head_v_d;
      spare_v_q <= spare_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= req_i.value;
    end
    head_q  <= head_d;
    spare_q <= spare_d;
  end

  assign rsp_valid_o = head_v_q;
  assign rsp_o       = head_q;

endmodule

// ===== rtl/lsws_checker.sv =====
`include "assert_macros.svh"

module lsws_checker import lsws_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      req_valid_i,
  input logic      req_stall_o,
  input lsws_req_t req_i,
  input logic      rsp_valid_o,
  input logic      rsp_stall_i,
  input lsws_rsp_t rsp_o
);

  `LSWS_IMPLY_NEXT(a_rsp_hold, rsp_valid_o && rsp_stall_i, rsp_valid_o && $stable(rsp_o), "stalled response changed")
  `LSWS_IMPLY_NEXT(a_quick_rsp, req_valid_i && !req_stall_o && req_i.command != CMD_SEARCH, rsp_valid_o, "push or pop response missing")
  `LSWS_IMPLY(a_empty_rsp, rsp_valid_o && rsp_o.status == STAT_EMPTY, rsp_o.depth == '0 && rsp_o.top_value == '0 && !rsp_o.found, "empty response inconsistent")
  `LSWS_IMPLY(a_miss_pos, rsp_valid_o && !rsp_o.found, rsp_o.found_position == '0, "position set on a miss")

endmodule

bind lifo_stack_with_search_unit lsws_checker u_lsws_checker (.*);

// ===== sim/lifo_stack_with_search_unit_tb.sv =====
module lifo_stack_with_search_unit_tb;
  import lsws_pkg::*;

  localparam int unsigned StackDepth = 64;
  localparam int          ClkPeriod  = 20;
  localparam int          RandItems  = 1250;
  localparam int          HoldCycles = 250;

  typedef struct {
    lsws_req_t req;
    bit        typed;
    lsws_rsp_t rsp;
  } dir_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      req_valid_i = 1'b0;
  logic      req_stall_o;
  lsws_req_t req_i       = '0;
  logic      rsp_valid_o;
  logic      rsp_stall_i = 1'b0;
  lsws_rsp_t rsp_o;

  logic [DataW-1:0] stk_words [StackDepth];
  int unsigned      stk_fill     = 0;
  lsws_rsp_t        exp_rsp_q[$];
  lsws_rsp_t        rsp_want;
  dir_row_t         dir_tab[$];
  int               errors       = 0;
  int               work_items   = 0;
  int               snd_idle_pct = 0;
  int               rsp_idle_pct = 0;
  bit               hold_req     = 1'b0;
  int               hold_left    = 0;

  lifo_stack_with_search_unit #(
    .STACK_DEPTH(StackDepth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_stall_o(req_stall_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_stall_i(rsp_stall_i),
    .rsp_o      (rsp_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic lsws_rsp_t stack_apply(input lsws_req_t r);
    lsws_rsp_t o;
    int unsigned i;
    o = '0;
    o.status = STAT_OK;
    case (r.command)
      CMD_PUSH: begin
        if (stk_fill >= StackDepth) begin
          o.status = STAT_FULL;
        end else begin
          stk_words[stk_fill] = r.value;
          stk_fill++;
        end
      end
      CMD_POP: begin
        if (stk_fill == 0) begin
          o.status = STAT_EMPTY;
        end else begin
          stk_fill--;
        end
      end
      CMD_SEARCH: begin
        if (stk_fill == 0) begin
          o.status = STAT_EMPTY;
        end else begin
          for (i = 0; i < stk_fill; i++) begin
            if (!o.found && stk_words[i] == r.value) begin
              o.found = 1'b1;
              o.found_position = PosW'(i);
            end
          end
        end
      end
      default: ;
    endcase
    if (stk_fill != 0) begin
      o.top_value = stk_words[stk_fill - 1];
    end
    o.depth = DepthW'(stk_fill);
    return o;
  endfunction

  function automatic dir_row_t drow(input lsws_cmd_e c, input logic [DataW-1:0] v,
                                    input bit typed = 1'b0,
                                    input logic [DataW-1:0] top = '0,
                                    input logic [DepthW-1:0] dep = '0,
                                    input logic fnd = 1'b0,
                                    input logic [PosW-1:0] pos = '0,
                                    input lsws_status_e st = STAT_OK);
    dir_row_t row;
    row.req.command = c;
    row.req.value = v;
    row.typed = typed;
    row.rsp.top_value = top;
    row.rsp.depth = dep;
    row.rsp.found = fnd;
    row.rsp.found_position = pos;
    row.rsp.status = st;
    return row;
  endfunction

  function automatic logic [DataW-1:0] pool_word(input int unsigned idx);
    case (idx)
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h0000_0001;
      5: return 32'h5555_5555;
      6: return 32'hAAAA_AAAA;
      default: return 32'h0000_8000;
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40 && stk_fill != 0) begin
      return stk_words[$urandom_range(stk_fill - 1)];
    end else if (r < 70) begin
      return pool_word($urandom_range(7));
    end
    return $urandom();
  endfunction

  function automatic void cmp_field(input string name, input logic [DataW-1:0] want,
                                    input logic [DataW-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  task automatic issue(input lsws_req_t r, input bit typed, input lsws_rsp_t want);
    lsws_rsp_t pred;
    while ($urandom_range(99) < snd_idle_pct) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (req_stall_o) @(posedge clk_i);
    pred = stack_apply(r);
    exp_rsp_q.push_back(typed ? want : pred);
    if (r.command != CMD_NOP) work_items++;
  endtask

  task automatic put(input lsws_cmd_e c, input logic [DataW-1:0] v);
    lsws_req_t r;
    r.command = c;
    r.value = v;
    issue(r, 1'b0, '0);
  endtask

  task automatic drain();
    req_valid_i <= 1'b0;
    while (exp_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic fill_burst();
    int unsigned n;
    n = $urandom_range(3, 1);
    while (stk_fill < StackDepth) begin
      put(CMD_PUSH, ($urandom_range(3) == 0) ? pick_word() : $urandom());
    end
    repeat (n) put(CMD_PUSH, $urandom());
    put(CMD_SEARCH, stk_words[StackDepth - 1]);
    put(CMD_SEARCH, stk_words[0]);
    repeat ($urandom_range(6, 2)) put(CMD_SEARCH, pick_word());
    while (stk_fill != 0) begin
      put(($urandom_range(9) == 0) ? CMD_SEARCH : CMD_POP, pick_word());
    end
    repeat (n) put(CMD_POP, $urandom());
  endtask

  task automatic random_walk();
    int unsigned r;
    lsws_cmd_e c;
    repeat ($urandom_range(40, 10)) begin
      r = $urandom_range(99);
      if (r < 42) c = CMD_PUSH;
      else if (r < 70) c = CMD_POP;
      else if (r < 95) c = CMD_SEARCH;
      else c = CMD_NOP;
      put(c, pick_word());
    end
  endtask

  task automatic noise();
    repeat ($urandom_range(15, 5)) put(lsws_cmd_e'($urandom_range(3)), $urandom());
  endtask

  always @(posedge clk_i) begin
    if (hold_req && hold_left == 0) begin
      hold_left = HoldCycles;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      rsp_stall_i <= 1'b1;
      hold_left--;
    end else begin
      rsp_stall_i <= ($urandom_range(99) < rsp_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && !rsp_stall_i) begin
      if (exp_rsp_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected response, expected none, actual %h", $time, rsp_o);
      end else begin
        rsp_want = exp_rsp_q.pop_front();
        cmp_field("top_value", rsp_want.top_value, rsp_o.top_value);
        cmp_field("depth", DataW'(rsp_want.depth), DataW'(rsp_o.depth));
        cmp_field("found", DataW'(rsp_want.found), DataW'(rsp_o.found));
        cmp_field("found_position", DataW'(rsp_want.found_position),
                  DataW'(rsp_o.found_position));
        cmp_field("status", DataW'(rsp_want.status), DataW'(rsp_o.status));
      end
    end
  end

  initial begin
    #(ClkPeriod * 300000);
    $display("[lifo_stack_with_search_unit] ERROR");
    $finish;
  end

  initial begin
    int unsigned ph;
    int unsigned r;
    dir_tab.push_back(drow(CMD_POP, 32'h0, 1'b1, '0, 7'd0, 1'b0, 6'd0, STAT_EMPTY));
    dir_tab.push_back(drow(CMD_SEARCH, 32'h0, 1'b1, '0, 7'd0, 1'b0, 6'd0, STAT_EMPTY));
    dir_tab.push_back(drow(CMD_NOP, 32'hFFFF_FFFF, 1'b1, '0, 7'd0, 1'b0, 6'd0, STAT_OK));
    dir_tab.push_back(drow(CMD_PUSH, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 7'd1, 1'b0, 6'd0,
                           STAT_OK));
    dir_tab.push_back(drow(CMD_PUSH, 32'h8000_0000, 1'b1, 32'h8000_0000, 7'd2, 1'b0, 6'd0,
                           STAT_OK));
    dir_tab.push_back(drow(CMD_SEARCH, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 7'd2, 1'b1, 6'd0,
                           STAT_OK));
    dir_tab.push_back(drow(CMD_SEARCH, 32'h8000_0000, 1'b1, 32'h8000_0000, 7'd2, 1'b1, 6'd1,
                           STAT_OK));
    dir_tab.push_back(drow(CMD_SEARCH, 32'h0, 1'b1, 32'h8000_0000, 7'd2, 1'b0, 6'd0,
                           STAT_OK));
    dir_tab.push_back(drow(CMD_PUSH, 32'h0));
    dir_tab.push_back(drow(CMD_PUSH, 32'hFFFF_FFFF));
    dir_tab.push_back(drow(CMD_PUSH, 32'h7FFF_FFFF));
    dir_tab.push_back(drow(CMD_SEARCH, 32'h7FFF_FFFF));
    dir_tab.push_back(drow(CMD_SEARCH, 32'hFFFF_FFFF));
    dir_tab.push_back(drow(CMD_NOP, 32'h5A5A_5A5A));
    dir_tab.push_back(drow(CMD_POP, 32'hFFFF_FFFF));
    dir_tab.push_back(drow(CMD_SEARCH, 32'h7FFF_FFFF));
    dir_tab.push_back(drow(CMD_POP, 32'h0));
    dir_tab.push_back(drow(CMD_POP, 32'h0));
    dir_tab.push_back(drow(CMD_SEARCH, 32'h0));
    dir_tab.push_back(drow(CMD_POP, 32'h0));
    dir_tab.push_back(drow(CMD_POP, 32'h0));
    dir_tab.push_back(drow(CMD_POP, 32'hFFFF_FFFF, 1'b1, '0, 7'd0, 1'b0, 6'd0, STAT_EMPTY));
    dir_tab.push_back(drow(CMD_PUSH, 32'h0000_0001));
    dir_tab.push_back(drow(CMD_SEARCH, 32'h0000_0001));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[k]) issue(dir_tab[k].req, dir_tab[k].typed, dir_tab[k].rsp);

    work_items = 0;
    for (ph = 0; ph < 3; ph++) begin
      drain();
      case (ph)
        0: begin
          snd_idle_pct = 23;
          rsp_idle_pct = 88;
        end
        1: begin
          snd_idle_pct = 88;
          rsp_idle_pct = 23;
        end
        default: begin
          snd_idle_pct = 0;
          rsp_idle_pct = 0;
          hold_req = 1'b1;
          fill_burst();
        end
      endcase
      while (work_items < (ph + 1) * RandItems / 3) begin
        r = $urandom_range(99);
        if (r < 12) fill_burst();
        else if (r < 85) random_walk();
        else noise();
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("[lifo_stack_with_search_unit] OK");
    end else begin
      $display("[lifo_stack_with_search_unit] ERROR");
    end
    $finish;
  end

endmodule
